FILE: rtl/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types and constants for the nearest node table: request and
// response payloads, memory port bundle, scan state machine encoding.
// ----------------------------------------------------------------------------
package nnt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int COORD_BITS  = 16;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int ID_BITS     = 11;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int DIST_BITS   = SQ_BITS + 1;

    // request codes
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_NEAREST = 1'b1;

    // response status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   req_type;
        t_coord point_x;
        t_coord point_y;
    } t_req;

    typedef struct packed {
        logic [ID_BITS-1:0] node_id;
        t_coord             near_x;
        t_coord             near_y;
        logic [1:0]         status;
    } t_rsp;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // point memory port bundle
    typedef struct packed {
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        t_point               wr_data;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

FILE: rtl/nnt_point_mem.sv
// ----------------------------------------------------------------------------
// nnt_point_mem
// Point store: one write port, one read port, read data registered.
// Entry i holds the coordinates of node id i+1.
// ----------------------------------------------------------------------------
module nnt_point_mem (
    input  logic              i_clk,
    input  nnt_pkg::t_mem_req i_req,
    output nnt_pkg::t_point   o_rd_data
);

    nnt_pkg::t_point r_mem [nnt_pkg::TABLE_DEPTH];
    nnt_pkg::t_point r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/nearest_node_table.sv
// ----------------------------------------------------------------------------
// nearest_node_table
// Planar point table: inserts store a point under the next id, nearest
// queries scan every stored point and return the closest by squared distance.
//
//   channel   direction  payload           handshake
//   in        input      nnt_pkg::t_req    i_in_valid  / o_in_ready
//   out       output     nnt_pkg::t_rsp    o_out_valid / i_out_ready
//
// An insert, or a query on an empty table, completes in the accept cycle.
// A query streams the stored points through the single memory read port,
// one point per cycle into a three stage distance pipeline; a drain state
// waits for the pipeline to empty, and a finish state loads the result.
// The result sits in an output register; a new transaction is taken in idle
// while it is free or being taken in the same cycle.
// Reset is synchronous; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_node_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  nnt_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output nnt_pkg::t_rsp o_out_data
);

    localparam int AW = nnt_pkg::ADDR_BITS;
    localparam int CW = nnt_pkg::COORD_BITS;

    nnt_pkg::t_state r_state, n_state;

    logic [nnt_pkg::CNT_BITS-1:0] r_count;
    logic [AW-1:0]                r_last;
    logic [AW-1:0]                r_rd_addr;
    nnt_pkg::t_coord              r_qx, r_qy;

    // pipeline: memory output, abs difference, square
    logic                         r_v0;
    logic [AW-1:0]                r_i0;
    nnt_pkg::t_point              w_rd_data;
    logic                         r_a_vld;
    logic [AW-1:0]                r_a_idx;
    nnt_pkg::t_point              r_a_pt;
    logic [CW-1:0]                r_adx, r_ady;
    logic                         r_b_vld;
    logic [AW-1:0]                r_b_idx;
    nnt_pkg::t_point              r_b_pt;
    logic [nnt_pkg::SQ_BITS-1:0]  r_sqx, r_sqy;

    // running best
    logic                          r_have;
    logic [AW-1:0]                 r_best_idx;
    nnt_pkg::t_point               r_best_pt;
    logic [nnt_pkg::DIST_BITS-1:0] r_best_d;

    logic          r_out_valid;
    nnt_pkg::t_rsp r_out;

    logic              w_accept;
    logic              w_issue_rd;
    logic              w_scan_last;
    logic              w_pipe_busy;
    logic              w_finish_load;
    logic              w_full;
    nnt_pkg::t_mem_req w_mem_req;
    nnt_pkg::t_rsp     w_imm_rsp;
    logic              w_imm_load;
    logic [CW:0]       w_dx, w_dy;
    logic [nnt_pkg::DIST_BITS-1:0] w_dist;
    logic [nnt_pkg::SQ_BITS-1:0]   w_ax_ext, w_ay_ext;

    // control outputs of the state machine
    always_comb begin
        o_in_ready    = 1'b0;
        w_issue_rd    = 1'b0;
        w_finish_load = 1'b0;
        unique case (r_state)
            nnt_pkg::S_IDLE:   o_in_ready = !r_out_valid || i_out_ready;
            nnt_pkg::S_SCAN:   w_issue_rd = 1'b1;
            nnt_pkg::S_DRAIN:  ;
            nnt_pkg::S_FINISH: w_finish_load = !r_out_valid || i_out_ready;
            default:           ;
        endcase
    end

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_scan_last = w_issue_rd && (r_rd_addr == r_last);
    assign w_pipe_busy = r_v0 || r_a_vld || r_b_vld;
    assign w_full      = (r_count == nnt_pkg::CNT_BITS'(nnt_pkg::TABLE_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nnt_pkg::S_IDLE: begin
                if (w_accept && i_in_data.req_type == nnt_pkg::REQ_NEAREST &&
                    r_count != '0) begin
                    n_state = nnt_pkg::S_SCAN;
                end
            end
            nnt_pkg::S_SCAN: begin
                if (w_scan_last) n_state = nnt_pkg::S_DRAIN;
            end
            nnt_pkg::S_DRAIN: begin
                if (!w_pipe_busy) n_state = nnt_pkg::S_FINISH;
            end
            nnt_pkg::S_FINISH: begin
                if (w_finish_load) n_state = nnt_pkg::S_IDLE;
            end
            default: n_state = nnt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // results that complete in the accept cycle
    always_comb begin
        w_imm_rsp  = '0;
        w_imm_load = 1'b0;
        if (w_accept) begin
            if (i_in_data.req_type == nnt_pkg::REQ_INSERT) begin
                w_imm_load = 1'b1;
                if (w_full) begin
                    w_imm_rsp.status = nnt_pkg::ST_FULL;
                end else begin
                    w_imm_rsp.node_id = nnt_pkg::ID_BITS'(r_count + 1'b1);
                    w_imm_rsp.status  = nnt_pkg::ST_OK;
                end
            end else if (r_count == '0) begin
                w_imm_load       = 1'b1;
                w_imm_rsp.status = nnt_pkg::ST_EMPTY;
            end
        end
    end

    // memory port: writes only in idle, reads only while scanning
    always_comb begin
        w_mem_req.wr_en     = w_accept && i_in_data.req_type == nnt_pkg::REQ_INSERT && !w_full;
        w_mem_req.wr_addr   = r_count[AW-1:0];
        w_mem_req.wr_data.x = i_in_data.point_x;
        w_mem_req.wr_data.y = i_in_data.point_y;
        w_mem_req.rd_en     = w_issue_rd;
        w_mem_req.rd_addr   = r_rd_addr;
    end

    nnt_point_mem u_point_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    // stored count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_mem_req.wr_en) begin
            r_count <= r_count + 1'b1;
        end
    end

    // query latch and scan address
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.req_type == nnt_pkg::REQ_NEAREST) begin
            r_qx      <= i_in_data.point_x;
            r_qy      <= i_in_data.point_y;
            r_last    <= AW'(r_count - 1'b1);
            r_rd_addr <= '0;
        end else if (w_issue_rd) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_v0    <= w_issue_rd;
            r_a_vld <= r_v0;
            r_b_vld <= r_a_vld;
        end
    end

    // absolute coordinate differences, one bit wider before folding
    always_comb begin
        w_dx = {w_rd_data.x[CW-1], w_rd_data.x} - {r_qx[CW-1], r_qx};
        w_dy = {w_rd_data.y[CW-1], w_rd_data.y} - {r_qy[CW-1], r_qy};
    end

    always_ff @(posedge i_clk) begin
        r_i0    <= r_rd_addr;
        r_a_idx <= r_i0;
        r_a_pt  <= w_rd_data;
        r_adx   <= CW'(w_dx[CW] ? -w_dx : w_dx);
        r_ady   <= CW'(w_dy[CW] ? -w_dy : w_dy);
    end

    // squares
    assign w_ax_ext = nnt_pkg::SQ_BITS'(r_adx);
    assign w_ay_ext = nnt_pkg::SQ_BITS'(r_ady);

    always_ff @(posedge i_clk) begin
        r_b_idx <= r_a_idx;
        r_b_pt  <= r_a_pt;
        r_sqx   <= w_ax_ext * w_ax_ext;
        r_sqy   <= w_ay_ext * w_ay_ext;
    end

    // sum with carry and compare; strict less keeps the lowest id on a tie
    assign w_dist = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (w_accept) begin
            r_have <= 1'b0;
        end else if (r_b_vld && (!r_have || w_dist < r_best_d)) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_vld && (!r_have || w_dist < r_best_d)) begin
            r_best_idx <= r_b_idx;
            r_best_pt  <= r_b_pt;
            r_best_d   <= w_dist;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_imm_load || w_finish_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_imm_load) begin
            r_out <= w_imm_rsp;
        end else if (w_finish_load) begin
            r_out.node_id <= nnt_pkg::ID_BITS'({1'b0, r_best_idx} + 1'b1);
            r_out.near_x  <= r_best_pt.x;
            r_out.near_y  <= r_best_pt.y;
            r_out.status  <= nnt_pkg::ST_OK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/nnt_checker.sv
// ----------------------------------------------------------------------------
// nnt_checker
// Port-level checks for the nearest node table, bound to the top level.
// ----------------------------------------------------------------------------
module nnt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input nnt_pkg::t_req i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input nnt_pkg::t_rsp o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // error responses carry no node
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != nnt_pkg::ST_OK |->
        o_out_data.node_id == '0 && o_out_data.near_x == '0 && o_out_data.near_y == '0)
        else $error("error response with node data");

    // good responses name a real node
    a_ok_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == nnt_pkg::ST_OK |-> o_out_data.node_id != '0)
        else $error("good response with id zero");

    // a query transaction either answers at once or blocks the input
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.req_type == nnt_pkg::REQ_NEAREST
        |=> o_out_valid || !o_in_ready)
        else $error("input taken during scan");

endmodule

bind nearest_node_table nnt_checker u_nnt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
